// File: rtl/hpr_pkg.sv
// Shared types and constants for the hex payload receiver.
package hpr_pkg;

	// Default values for the top-level parameter and the config registers
	localparam int LINE_LEN_DEF = 128;
	localparam logic [15:0] MAX_BYTES_RST = 16'd64;
	localparam logic [14:0] TIMEOUT_RST = 15'd1000;

	// Configuration register indexes
	localparam int CFG_ADDR_W = 1;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_BYTES = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT = 1'd1;

	// Input word function codes
	localparam logic [1:0] FUNC_CHAR = 2'd0;
	localparam logic [1:0] FUNC_TICK = 2'd1;
	localparam logic [1:0] FUNC_START = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_TIMEOUT = 2'd2;

	// Session phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;

	// Session state, except the line length (its width follows LINE_LEN)
	typedef struct packed {
		logic [1:0] phase;
		logic [3:0] prefix_progress;
		logic prefix_mismatch;
		logic [16:0] digit_count;
		logic [3:0] high_nibble;
		logic [14:0] ticks_left;
	} hpr_state_t;

	// One result word
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [15:0] byte_index;
		logic [15:0] byte_count;
		logic last;
	} hpr_result_t;

endpackage

// File: rtl/hpr_step.sv
// Next-state and result logic for one received word of the hex payload receiver.
module hpr_step #(
	parameter int LINE_LEN = hpr_pkg::LINE_LEN_DEF,
	parameter int LEN_W = $clog2(LINE_LEN)
) (
	input logic [1:0] func,
	input logic [7:0] rx_char,
	input hpr_pkg::hpr_state_t state,
	input logic [LEN_W-1:0] line_length,
	input logic [15:0] max_bytes,
	input logic [14:0] timeout_ticks,
	output hpr_pkg::hpr_state_t state_nxt,
	output logic [LEN_W-1:0] line_length_nxt,
	output logic emit,
	output hpr_pkg::hpr_result_t result
);

	localparam logic [LEN_W-1:0] LINE_MAX = LEN_W'(LINE_LEN - 1);
	localparam logic [3:0] PREFIX_LEN = 4'd10;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_NUL = 8'h00;

	// Expected header prefix "+CTM2MRECV"
	function automatic logic [7:0] prefix_char(input logic [3:0] idx);
		case (idx)
			4'd0: prefix_char = 8'h2b;
			4'd1: prefix_char = 8'h43;
			4'd2: prefix_char = 8'h54;
			4'd3: prefix_char = 8'h4d;
			4'd4: prefix_char = 8'h32;
			4'd5: prefix_char = 8'h4d;
			4'd6: prefix_char = 8'h52;
			4'd7: prefix_char = 8'h45;
			4'd8: prefix_char = 8'h43;
			4'd9: prefix_char = 8'h56;
			default: prefix_char = 8'h00;
		endcase
	endfunction

	// Hex digit value; anything else is zero
	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) d = c - 8'h30;
		else if (c >= 8'h61 && c <= 8'h66) d = c - 8'h57;
		else if (c >= 8'h41 && c <= 8'h46) d = c - 8'h37;
		nibble_of = d[3:0];
	endfunction

	logic is_term_hdr;
	logic is_term_data;
	logic below_cap;
	logic [14:0] ticks_dec;

	assign is_term_hdr = (rx_char == CH_CR) || (rx_char == CH_LF) || (rx_char == CH_COLON);
	assign is_term_data = (rx_char == CH_CR) || (rx_char == CH_LF) || (rx_char == CH_NUL);
	assign below_cap = state.digit_count < {max_bytes, 1'b0};
	assign ticks_dec = (state.ticks_left != 15'd0) ? state.ticks_left - 15'd1 : state.ticks_left;

	always_comb begin
		state_nxt = state;
		line_length_nxt = line_length;
		emit = 1'b0;
		result = '0;
		case (func)
			// New session: clear everything, load the tick budget; a zero budget times out at once
			hpr_pkg::FUNC_START: begin
				state_nxt.prefix_progress = 4'd0;
				state_nxt.prefix_mismatch = 1'b0;
				line_length_nxt = '0;
				state_nxt.digit_count = 17'd0;
				state_nxt.high_nibble = 4'd0;
				state_nxt.ticks_left = timeout_ticks;
				if (timeout_ticks == 15'd0) begin
					state_nxt.phase = hpr_pkg::PH_IDLE;
					emit = 1'b1;
					result.kind = hpr_pkg::KIND_TIMEOUT;
					result.last = 1'b1;
				end else begin
					state_nxt.phase = hpr_pkg::PH_HEADER;
				end
			end
			// Idle tick: count down, time out at zero
			hpr_pkg::FUNC_TICK: begin
				if (state.phase != hpr_pkg::PH_IDLE) begin
					state_nxt.ticks_left = ticks_dec;
					if (ticks_dec == 15'd0) begin
						state_nxt.phase = hpr_pkg::PH_IDLE;
						emit = 1'b1;
						result.kind = hpr_pkg::KIND_TIMEOUT;
						result.last = 1'b1;
					end
				end
			end
			hpr_pkg::FUNC_CHAR: begin
				if (state.phase == hpr_pkg::PH_HEADER) begin
					// Header line: track prefix match, watch for line end
					if (is_term_hdr) begin
						if (line_length != '0 && rx_char == CH_COLON &&
						    !state.prefix_mismatch &&
						    state.prefix_progress == PREFIX_LEN) begin
							state_nxt.phase = hpr_pkg::PH_DATA;
						end
						line_length_nxt = '0;
						state_nxt.prefix_progress = 4'd0;
						state_nxt.prefix_mismatch = 1'b0;
					end else if (line_length >= LINE_MAX) begin
						line_length_nxt = '0;
						state_nxt.prefix_progress = 4'd0;
						state_nxt.prefix_mismatch = 1'b0;
					end else begin
						if (!state.prefix_mismatch && state.prefix_progress < PREFIX_LEN) begin
							if (rx_char == prefix_char(state.prefix_progress))
								state_nxt.prefix_progress = state.prefix_progress + 4'd1;
							else
								state_nxt.prefix_mismatch = 1'b1;
						end
						line_length_nxt = line_length + LEN_W'(1);
					end
				end else if (state.phase == hpr_pkg::PH_DATA) begin
					// Payload: digit pairs make bytes until a terminator
					if (!is_term_data) begin
						if (below_cap) begin
							state_nxt.digit_count = state.digit_count + 17'd1;
							if (!state.digit_count[0]) begin
								state_nxt.high_nibble = nibble_of(rx_char);
							end else begin
								emit = 1'b1;
								result.kind = hpr_pkg::KIND_DATA;
								result.data_byte = {state.high_nibble, nibble_of(rx_char)};
								result.byte_index = state.digit_count[16:1];
							end
						end
					end else if (state.digit_count != 17'd0) begin
						state_nxt.phase = hpr_pkg::PH_IDLE;
						emit = 1'b1;
						result.kind = hpr_pkg::KIND_DONE;
						result.byte_count = state.digit_count[16:1];
						result.last = 1'b1;
					end
				end
			end
			default: begin
				state_nxt = state;
			end
		endcase
	end

endmodule

// File: rtl/at_hex_payload_receiver_core.sv
// Top level of the hex payload receiver: input register, session state, result register.
//
//  port group     | dir | tdata (low bit up)                      | tuser | tlast
//  s_*            | in  | rx_char[7:0]                            | func  | -
//  m_*            | out | data_byte, byte_index, byte_count       | kind  | last
//  cfg_*          | in  | 0 max_bytes, 1 timeout_ticks            | -     | -
//
// One word per cycle sustained while the result side is not stalled; a result
// passes the input register, then the result register. Reset clears the registers to
// max_bytes 64, timeout_ticks 1000 and an idle session. A stalled result
// holds the result register and the input register; the input side stops
// only when both are full.
module at_hex_payload_receiver_core #(
	parameter int LINE_LEN = hpr_pkg::LINE_LEN_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata,  // [7:0] rx_char
	input logic [1:0] s_tuser,  // [1:0] func
	output logic m_tvalid,
	input logic m_tready,
	output logic [39:0] m_tdata,  // [7:0] data_byte, [23:8] byte_index, [39:24] byte_count
	output logic [1:0] m_tuser,   // [1:0] kind
	output logic m_tlast,
	input logic cfg_we,
	input logic [hpr_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input logic [15:0] cfg_wdata
);

	localparam int LEN_W = $clog2(LINE_LEN);

	logic in_valid_s1;
	logic [1:0] func_s1;
	logic [7:0] char_s1;
	logic out_valid_q;
	logic out_free;
	logic advance;
	logic [15:0] max_bytes_q;
	logic [14:0] timeout_q;
	hpr_pkg::hpr_state_t state_q;
	hpr_pkg::hpr_state_t state_nxt;
	logic [LEN_W-1:0] line_len_q;
	logic [LEN_W-1:0] line_len_nxt;
	logic emit;
	hpr_pkg::hpr_result_t result;
	hpr_pkg::hpr_result_t result_q;

	assign out_free = !out_valid_q || m_tready;
	assign advance = in_valid_s1 && out_free;
	assign s_tready = !in_valid_s1 || out_free;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= hpr_pkg::MAX_BYTES_RST;
			timeout_q <= hpr_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			if (cfg_addr == hpr_pkg::REG_MAX_BYTES) max_bytes_q <= cfg_wdata;
			else if (cfg_addr == hpr_pkg::REG_TIMEOUT) timeout_q <= cfg_wdata[14:0];
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1 <= s_tuser;
			char_s1 <= s_tdata;
		end
	end

	hpr_step #(
		.LINE_LEN(LINE_LEN),
		.LEN_W(LEN_W)
	) u_step (
		.func(func_s1),
		.rx_char(char_s1),
		.state(state_q),
		.line_length(line_len_q),
		.max_bytes(max_bytes_q),
		.timeout_ticks(timeout_q),
		.state_nxt(state_nxt),
		.line_length_nxt(line_len_nxt),
		.emit(emit),
		.result(result)
	);

	// Session state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			line_len_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
			line_len_q <= line_len_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) result_q <= result;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = result_q.kind;
	assign m_tdata = {result_q.byte_count, result_q.byte_index, result_q.data_byte};
	assign m_tlast = result_q.last;

`ifndef ASSERT_OFF
	// A live session always has ticks left
	a_ticks_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase != hpr_pkg::PH_IDLE |-> state_q.ticks_left != 15'd0)
		else $error("live session with no ticks left");

	// Data mode starts with an empty line and a cleared prefix
	a_data_line_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == hpr_pkg::PH_DATA |-> line_len_q == '0 && state_q.prefix_progress == 4'd0)
		else $error("line not cleared in data mode");

	// Input side only stalls when both registers are full and output is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> in_valid_s1 && out_valid_q && !m_tready)
		else $error("input stalled without cause");

	// Data bytes never end a session; done and timeout always do
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tlast == (m_tuser != hpr_pkg::KIND_DATA))
		else $error("last flag does not match result kind");

	// A result only appears after an item was processed
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(advance))
		else $error("result without processed item");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the AT hex payload receiver core.
module testbench;

	localparam int LINE_LEN = hpr_pkg::LINE_LEN_DEF;
	localparam int TAG_LEN = 10;
	localparam string RECV_TAG = "+CTM2MRECV";
	localparam string HEX_DIGITS = "0123456789abcdefABCDEF";
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 3000;
	localparam int ITEM_TARGET = 1050;
	localparam int REPORT_MAX = 10;

	// Tracks the session state of the receiver and the result words still owed by it
	class payload_checker;
		logic [15:0] max_bytes;
		logic [14:0] timeout_ticks;
		logic [1:0] phase;
		int line_len;
		logic [3:0] tag_pos;
		bit tag_bad;
		logic [16:0] digits;
		logic [3:0] hi_nib;
		logic [14:0] ticks_left;
		hpr_pkg::hpr_result_t awaited[$];
		int errors;
		int n_bytes;
		int n_done;
		int n_timeout;

		function new();
			max_bytes = hpr_pkg::MAX_BYTES_RST;
			timeout_ticks = hpr_pkg::TIMEOUT_RST;
			phase = hpr_pkg::PH_IDLE;
			clear_line();
			digits = '0;
			hi_nib = '0;
			ticks_left = '0;
			errors = 0;
			n_bytes = 0;
			n_done = 0;
			n_timeout = 0;
		endfunction

		function void clear_line();
			line_len = 0;
			tag_pos = '0;
			tag_bad = 1'b0;
		endfunction

		function logic [3:0] hex_value(logic [7:0] c);
			if (c >= "0" && c <= "9") return 4'(c - "0");
			if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
			if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
			return 4'd0;
		endfunction

		function void set_reg(logic [hpr_pkg::CFG_ADDR_W-1:0] idx, logic [15:0] val);
			if (idx == hpr_pkg::REG_MAX_BYTES) max_bytes = val;
			else timeout_ticks = val[14:0];
		endfunction

		// Advance the session by one accepted word; returns 1 if the word was not ignored
		function bit decode_item(logic [1:0] f, logic [7:0] c);
			hpr_pkg::hpr_result_t r;
			bit live;
			bit emit;
			live = (f == hpr_pkg::FUNC_START) ||
				((f == hpr_pkg::FUNC_CHAR || f == hpr_pkg::FUNC_TICK) &&
				 phase != hpr_pkg::PH_IDLE);
			emit = 1'b0;
			r = '0;
			case (f)
				hpr_pkg::FUNC_START: begin
					clear_line();
					digits = '0;
					hi_nib = '0;
					ticks_left = timeout_ticks;
					if (ticks_left == 0) begin
						phase = hpr_pkg::PH_IDLE;
						r.kind = hpr_pkg::KIND_TIMEOUT;
						r.last = 1'b1;
						emit = 1'b1;
					end else begin
						phase = hpr_pkg::PH_HEADER;
					end
				end
				hpr_pkg::FUNC_TICK: begin
					if (phase != hpr_pkg::PH_IDLE) begin
						if (ticks_left != 0) ticks_left--;
						if (ticks_left == 0) begin
							phase = hpr_pkg::PH_IDLE;
							r.kind = hpr_pkg::KIND_TIMEOUT;
							r.last = 1'b1;
							emit = 1'b1;
						end
					end
				end
				hpr_pkg::FUNC_CHAR: begin
					if (phase == hpr_pkg::PH_HEADER) begin
						// header line: match the receive tag, colon opens the payload
						if (c == CH_CR || c == CH_LF || c == CH_COLON) begin
							if (line_len != 0 && c == CH_COLON && !tag_bad &&
							    tag_pos == TAG_LEN)
								phase = hpr_pkg::PH_DATA;
							clear_line();
						end else if (line_len >= LINE_LEN - 1) begin
							clear_line();
						end else begin
							if (!tag_bad && tag_pos < TAG_LEN) begin
								if (c == RECV_TAG[tag_pos]) tag_pos++;
								else tag_bad = 1'b1;
							end
							line_len++;
						end
					end else if (phase == hpr_pkg::PH_DATA) begin
						// payload: digit pairs up to the cap, terminator ends it
						if (c != CH_CR && c != CH_LF && c != CH_NUL) begin
							if (digits < {max_bytes, 1'b0}) begin
								if (!digits[0]) begin
									hi_nib = hex_value(c);
								end else begin
									r.kind = hpr_pkg::KIND_DATA;
									r.data_byte = {hi_nib, hex_value(c)};
									r.byte_index = digits[16:1];
									emit = 1'b1;
								end
								digits++;
							end
						end else if (digits != 0) begin
							phase = hpr_pkg::PH_IDLE;
							r.kind = hpr_pkg::KIND_DONE;
							r.byte_count = digits[16:1];
							r.last = 1'b1;
							emit = 1'b1;
						end
					end
				end
				default: ;
			endcase
			if (emit) awaited.push_back(r);
			return live;
		endfunction

		function void report(string what, hpr_pkg::hpr_result_t want,
				hpr_pkg::hpr_result_t got);
			errors++;
			if (errors <= REPORT_MAX)
				$display("%s: want kind %0d data %02h index %0d count %0d last %0b, ",
					what, want.kind, want.data_byte, want.byte_index, want.byte_count,
					want.last,
					"got kind %0d data %02h index %0d count %0d last %0b",
					got.kind, got.data_byte, got.byte_index, got.byte_count, got.last);
		endfunction

		function void compare_word(hpr_pkg::hpr_result_t got);
			hpr_pkg::hpr_result_t want;
			if (awaited.size() == 0) begin
				report("unexpected word", '0, got);
				return;
			end
			want = awaited.pop_front();
			if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
					got.byte_index !== want.byte_index || got.byte_count !== want.byte_count ||
					got.last !== want.last)
				report("mismatch", want, got);
			if (want.kind == hpr_pkg::KIND_DATA) n_bytes++;
			else if (want.kind == hpr_pkg::KIND_DONE) n_done++;
			else n_timeout++;
		endfunction

		function void close_out();
			if (awaited.size() != 0) begin
				errors += awaited.size();
				$display("%0d result words never arrived", awaited.size());
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [hpr_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [15:0] cfg_wdata = '0;

	payload_checker sb = new();
	int burst_left = 0;
	int total_items = 0;
	int live_items = 0;
	int settings_used = 0;
	int rx_mode = 0;
	int rx_left = 0;
	int rx_cyc = 0;

	at_hex_payload_receiver_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Receiver stall pattern: switches between always ready, coin flip, sparse, periodic
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 300);
		end
		rx_left--;
		rx_cyc++;
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= ((rx_cyc % 7) < 2);
		endcase
	end

	// Output monitor
	always @(posedge clk) begin : monitor
		hpr_pkg::hpr_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = m_tuser;
			got.data_byte = m_tdata[7:0];
			got.byte_index = m_tdata[23:8];
			got.byte_count = m_tdata[39:24];
			got.last = m_tlast;
			sb.compare_word(got);
		end
	end

	// Watchdog on cycles with no word moving on either side
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
			else quiet++;
		end
		$display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
		$display("testbench: errors");
		$finish;
	end

	// One input word, sent in bursts with random gaps
	task automatic send_word(input logic [1:0] f, input logic [7:0] c);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ?
				$urandom_range(40, 120) : $urandom_range(1, 10);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tuser <= f;
		do @(posedge clk); while (!s_tready);
		total_items++;
		if (sb.decode_item(f, c)) live_items++;
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) send_word(hpr_pkg::FUNC_CHAR, s[i]);
	endtask

	function automatic logic [7:0] pick_term();
		case ($urandom_range(0, 2))
			0: return CH_CR;
			1: return CH_LF;
			default: return CH_NUL;
		endcase
	endfunction

	// Wait until every owed word is out and the pipeline has emptied
	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_regs(input logic [15:0] mb, input logic [14:0] to);
		drain();
		cfg_we <= 1'b1;
		cfg_addr <= hpr_pkg::REG_MAX_BYTES;
		cfg_wdata <= mb;
		@(posedge clk);
		sb.set_reg(hpr_pkg::REG_MAX_BYTES, mb);
		cfg_addr <= hpr_pkg::REG_TIMEOUT;
		cfg_wdata <= {1'b0, to};
		@(posedge clk);
		sb.set_reg(hpr_pkg::REG_TIMEOUT, {1'b0, to});
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Header-mode line of random printable text
	task automatic junk_line();
		int n;
		n = $urandom_range(0, 12);
		repeat (n) send_word(hpr_pkg::FUNC_CHAR, 8'($urandom_range(32, 126)));
		case ($urandom_range(0, 2))
			0: send_word(hpr_pkg::FUNC_CHAR, CH_CR);
			1: send_word(hpr_pkg::FUNC_CHAR, CH_LF);
			default: send_word(hpr_pkg::FUNC_CHAR, CH_COLON);
		endcase
	endtask

	// Hex digits sized around the current cap, with stray bytes and ticks, then a terminator
	task automatic payload();
		int n;
		logic [7:0] c;
		if ($urandom_range(0, 4) == 0) send_word(hpr_pkg::FUNC_CHAR, pick_term());
		if (sb.max_bytes <= 4) n = $urandom_range(0, 2 * sb.max_bytes + 3);
		else if ($urandom_range(0, 9) == 0) n = $urandom_range(20, 60);
		else n = $urandom_range(0, 12);
		repeat (n) begin
			if ($urandom_range(0, 19) == 0)
				send_word(hpr_pkg::FUNC_TICK, 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 4) == 0) c = 8'($urandom_range(0, 255));
			else c = HEX_DIGITS[$urandom_range(0, 21)];
			send_word(hpr_pkg::FUNC_CHAR, c);
		end
		send_word(hpr_pkg::FUNC_CHAR, pick_term());
	endtask

	task automatic run_session();
		int pick;
		int n;
		int i;
		string hdr;
		logic [7:0] c;
		send_word(hpr_pkg::FUNC_START, 8'($urandom_range(0, 255)));
		repeat ($urandom_range(0, 1)) junk_line();
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			send_text("+CTM2MRECV:");
			payload();
		end else if (pick < 63) begin
			// one tag character wrong
			hdr = RECV_TAG;
			i = $urandom_range(0, TAG_LEN - 1);
			c = 8'($urandom_range(32, 126));
			if (c == hdr[i]) c = "#";
			hdr[i] = c;
			send_text({hdr, ":"});
			send_text("0a1b");
			send_word(hpr_pkg::FUNC_CHAR, CH_CR);
		end else if (pick < 68) begin
			// empty line and truncated tag
			send_word(hpr_pkg::FUNC_CHAR, CH_COLON);
			send_text("+CTM2M:12");
			send_word(hpr_pkg::FUNC_CHAR, CH_LF);
		end else if (pick < 72) begin
			// full tag ended by CR stays in header mode
			send_text("+CTM2MRECV");
			send_word(hpr_pkg::FUNC_CHAR, CH_CR);
			send_text("ab");
		end else if (pick < 78) begin
			// overlong line wraps, then a proper header
			n = $urandom_range(LINE_LEN - 3, LINE_LEN + 8);
			if ($urandom_range(0, 1) == 0) send_text(RECV_TAG);
			repeat (n) begin
				c = 8'($urandom_range(0, 255));
				if (c == CH_CR || c == CH_LF || c == CH_COLON) c = "x";
				send_word(hpr_pkg::FUNC_CHAR, c);
			end
			send_word(hpr_pkg::FUNC_CHAR, CH_COLON);
			send_text("+CTM2MRECV:");
			payload();
		end else if (pick < 85) begin
			// left open, next start restarts it
			send_text("+CTM2MRECV:");
			repeat ($urandom_range(0, 5))
				send_word(hpr_pkg::FUNC_CHAR, HEX_DIGITS[$urandom_range(0, 21)]);
		end else if (pick < 93) begin
			repeat ($urandom_range(1, 25)) begin
				send_word(hpr_pkg::FUNC_TICK, 8'($urandom_range(0, 255)));
				if ($urandom_range(0, 3) == 0)
					send_word(hpr_pkg::FUNC_CHAR, 8'($urandom_range(32, 126)));
			end
			send_text("+CTM2MRECV:");
			payload();
		end else begin
			repeat ($urandom_range(5, 20))
				send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin : stimulus
		logic [15:0] mb_tab[6];
		logic [14:0] to_tab[6];
		logic [15:0] mb;
		logic [14:0] to;
		int target;
		int step;
		mb_tab = '{16'd0, 16'd1, 16'hFFFF, 16'd3, 16'd2, 16'd8};
		to_tab = '{15'h7FFF, 15'd1, 15'd0, 15'd4, 15'd20, 15'd1000};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: ignored words, then a two-byte and a one-digit payload at the reset settings
		send_word(FUNC_UNUSED, 8'hFF);
		send_word(hpr_pkg::FUNC_CHAR, 8'hFF);
		send_word(hpr_pkg::FUNC_TICK, 8'h00);
		send_word(hpr_pkg::FUNC_START, 8'h00);
		send_text("+CTM2MRECV:");
		send_word(hpr_pkg::FUNC_CHAR, CH_CR);
		send_text("fFg0");
		send_word(hpr_pkg::FUNC_CHAR, CH_CR);
		send_word(hpr_pkg::FUNC_START, 8'h55);
		send_text("+CTM2MRECV:9");
		send_word(hpr_pkg::FUNC_CHAR, CH_NUL);

		// Random sessions under a series of register settings
		step = 0;
		while (total_items < ITEM_TARGET) begin
			if (step < 6) begin
				mb = mb_tab[step];
				to = to_tab[step];
			end else begin
				case ($urandom_range(0, 5))
					0: mb = 16'($urandom_range(0, 4));
					1: mb = 16'($urandom_range(5, 64));
					2: mb = 16'hFFFF;
					default: mb = 16'($urandom_range(1, 20));
				endcase
				case ($urandom_range(0, 7))
					0: to = 15'($urandom_range(0, 3));
					1, 2: to = 15'($urandom_range(4, 40));
					3: to = 15'h7FFF;
					default: to = 15'($urandom_range(200, 2000));
				endcase
			end
			set_regs(mb, to);
			target = live_items + ((to == 0) ? 15 : $urandom_range(60, 140));
			while (live_items < target && total_items < ITEM_TARGET) run_session();
			step++;
		end

		drain();
		repeat (10) @(posedge clk);
		sb.close_out();
		$display("run: %0d words sent (%0d acted on) under %0d register settings",
			total_items, live_items, settings_used);
		$display("results checked: %0d bytes, %0d done, %0d timeout; %0d errors",
			sb.n_bytes, sb.n_done, sb.n_timeout, sb.errors);
		if (sb.errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end
endmodule
